[src/kfr_pkg.sv]
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared types and constants for the KISS frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package kfr_pkg;

  // frame store geometry
  localparam int MaxFrame = 64;
  localparam int AddrW    = $clog2(MaxFrame);
  localparam int CntW     = $clog2(MaxFrame + 1);
  localparam int MinLenW  = 6;
  localparam int CmpW     = CntW + MinLenW;

  // protocol bytes
  localparam logic [7:0] FEND     = 8'hC0;
  localparam logic [7:0] FESC     = 8'hDB;
  localparam logic [7:0] TFEND    = 8'hDC;
  localparam logic [7:0] TFESC    = 8'hDD;
  localparam logic [7:0] CMD_DATA = 8'h00;

  localparam logic [MinLenW-1:0] MIN_RAW_RESET = 6'd14;

  // input operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_CMD   = 2'd1,
    MODE_FRAME = 2'd2
  } rx_mode_e;

  typedef enum logic [1:0] {
    DR_IDLE = 2'd0,
    DR_READ = 2'd1,
    DR_LOAD = 2'd2
  } drain_state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  // write port into the frame store
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  // request from the receiver to start a readout burst
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] count;
  } drain_req_t;

endpackage

`default_nettype wire

[src/kfr_store.sv]
// ----------------------------------------------------------------------------
// kfr_store
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kfr_store (
  input  wire logic                     clk_i,
  input  wire kfr_pkg::store_wr_t       wr_i,
  input  wire logic                     rd_en_i,
  input  wire logic [kfr_pkg::AddrW-1:0] rd_addr_i,
  output      logic [7:0]               rd_data_o
);

  logic [7:0] mem [kfr_pkg::MaxFrame];
  logic [7:0] rd_data_q;

  // write side
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read side, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[src/kfr_rx.sv]
// ----------------------------------------------------------------------------
// kfr_rx
// Byte-level receiver: frame hunting, command check, unescaping and store
// writes; requests a readout burst on an accepted closing frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module kfr_rx (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire kfr_pkg::in_word_t             word_i,
  input  wire logic [kfr_pkg::MinLenW-1:0]   min_raw_len_i,
  output      kfr_pkg::store_wr_t            wr_o,
  output      kfr_pkg::drain_req_t           req_o
);

  kfr_pkg::rx_mode_e            mode_q, mode_d;
  logic [kfr_pkg::CntW-1:0]     raw_q, raw_d;
  logic [kfr_pkg::CntW-1:0]     stored_q, stored_d;
  logic                         esc_q, esc_d;
  logic                         ovf_q, ovf_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= kfr_pkg::MODE_HUNT;
      raw_q    <= '0;
      stored_q <= '0;
      esc_q    <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      raw_q    <= raw_d;
      stored_q <= stored_d;
      esc_q    <= esc_d;
      ovf_q    <= ovf_d;
    end
  end

  // decode of one received word
  always_comb begin
    logic       st_en;
    logic [7:0] st_data;
    logic [7:0] b;
    st_en    = 1'b0;
    st_data  = 8'h00;
    b        = word_i.rx_byte;
    mode_d   = mode_q;
    raw_d    = raw_q;
    stored_d = stored_q;
    esc_d    = esc_q;
    ovf_d    = ovf_q;
    req_o    = '0;
    wr_o     = '0;

    if (accept_i) begin
      if (word_i.op == kfr_pkg::OP_RESET) begin
        mode_d = kfr_pkg::MODE_HUNT;
      end else begin
        unique case (mode_q)
          kfr_pkg::MODE_CMD: begin
            if (b == kfr_pkg::FEND) begin
              mode_d = kfr_pkg::MODE_CMD;
            end else if (b == kfr_pkg::CMD_DATA) begin
              mode_d   = kfr_pkg::MODE_FRAME;
              raw_d    = '0;
              stored_d = '0;
              esc_d    = 1'b0;
              ovf_d    = 1'b0;
            end else begin
              mode_d = kfr_pkg::MODE_HUNT;
            end
          end
          kfr_pkg::MODE_FRAME: begin
            if (b == kfr_pkg::FEND) begin
              // closing frame end: release the frame if long enough, intact and not empty
              if (!ovf_q && stored_q != '0 &&
                  kfr_pkg::CmpW'(raw_q) > kfr_pkg::CmpW'(min_raw_len_i)) begin
                req_o.start = 1'b1;
                req_o.count = stored_q;
              end
              mode_d = kfr_pkg::MODE_CMD;
              esc_d  = 1'b0;
            end else if (!ovf_q) begin
              if (raw_q >= kfr_pkg::CntW'(kfr_pkg::MaxFrame)) begin
                ovf_d = 1'b1;
              end else begin
                raw_d = raw_q + 1'b1;
                if (esc_q) begin
                  esc_d = 1'b0;
                  if (b == kfr_pkg::TFESC) begin
                    st_en   = 1'b1;
                    st_data = kfr_pkg::FESC;
                  end else if (b == kfr_pkg::TFEND) begin
                    st_en   = 1'b1;
                    st_data = kfr_pkg::FEND;
                  end
                end else if (b == kfr_pkg::FESC) begin
                  esc_d = 1'b1;
                end else begin
                  st_en   = 1'b1;
                  st_data = b;
                end
              end
            end
          end
          default: begin
            // hunting, and the unused mode code
            mode_d = (b == kfr_pkg::FEND) ? kfr_pkg::MODE_CMD : kfr_pkg::MODE_HUNT;
          end
        endcase
      end
    end

    // store write, guarded against a full store
    if (st_en && stored_q < kfr_pkg::CntW'(kfr_pkg::MaxFrame)) begin
      wr_o.en   = 1'b1;
      wr_o.addr = stored_q[kfr_pkg::AddrW-1:0];
      wr_o.data = st_data;
      stored_d  = stored_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

[src/kfr_drain.sv]
// ----------------------------------------------------------------------------
// kfr_drain
// Readout sequencer: walks the frame store and feeds the output register,
// marking the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module kfr_drain (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kfr_pkg::drain_req_t           req_i,
  output      logic                          busy_o,
  output      logic                          rd_en_o,
  output      logic [kfr_pkg::AddrW-1:0]     rd_addr_o,
  input  wire logic [7:0]                    rd_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      kfr_pkg::out_word_t            out_word_o
);

  kfr_pkg::drain_state_e        state_q, state_d;
  logic [kfr_pkg::CntW-1:0]     idx_q, idx_d;
  logic [kfr_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  kfr_pkg::out_word_t           out_word_q;
  logic                         load;
  logic                         is_last;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfr_pkg::DR_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q.out_byte <= rd_data_i;
      out_word_q.last     <= is_last;
    end
  end

  assign is_last = (idx_q + 1'b1) == cnt_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q[kfr_pkg::AddrW-1:0];
    load      = 1'b0;
    unique case (state_q)
      kfr_pkg::DR_IDLE: begin
        if (req_i.start) begin
          idx_d   = '0;
          cnt_d   = req_i.count;
          state_d = kfr_pkg::DR_READ;
        end
      end
      kfr_pkg::DR_READ: begin
        // issue a read once the output register frees up this cycle
        if (!out_valid_q || !out_stall_i) begin
          rd_en_o = 1'b1;
          state_d = kfr_pkg::DR_LOAD;
        end
      end
      kfr_pkg::DR_LOAD: begin
        load    = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = is_last ? kfr_pkg::DR_IDLE : kfr_pkg::DR_READ;
      end
      default: begin
        state_d = kfr_pkg::DR_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign busy_o      = state_q != kfr_pkg::DR_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

[src/kiss_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// kiss_frame_receiver_unit
// KISS link receiver: unescapes data frames into a byte store and bursts
// each accepted frame out with a last mark on its final byte.
// ----------------------------------------------------------------------------
//
//   channel   signals                              word
//   --------  -----------------------------------  --------------------------
//   input     in_valid_i, in_stall_o, in_word_i     op, rx_byte
//   output    out_valid_o, out_stall_i, out_word_o  out_byte, last
//   config    cfg_we_i, cfg_wdata_i                 min_raw_len (6 bits)
//
// An input word is decoded and written to the store at the edge that accepts
// it. A released frame is read back through the store's registered read
// and the single output register, the next byte only once the last is
// loaded. in_stall_o is high for the whole burst. Output stalls pause the
// burst with no loss. Reset returns to hunting with min_raw_len 14; the
// store needs no clearing, so words are taken as soon as reset is released.
`default_nettype none

module kiss_frame_receiver_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire kfr_pkg::in_word_t           in_word_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      kfr_pkg::out_word_t          out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [kfr_pkg::MinLenW-1:0] cfg_wdata_i
);

  logic [kfr_pkg::MinLenW-1:0] min_raw_len_q;
  logic                        accept;
  logic                        busy;
  kfr_pkg::store_wr_t          wr;
  kfr_pkg::drain_req_t         req;
  logic                        rd_en;
  logic [kfr_pkg::AddrW-1:0]   rd_addr;
  logic [7:0]                  rd_data;

  // length threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_raw_len_q <= kfr_pkg::MIN_RAW_RESET;
    end else if (cfg_we_i) begin
      min_raw_len_q <= cfg_wdata_i;
    end
  end

  // input handshake
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  kfr_rx u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .word_i        (in_word_i),
    .min_raw_len_i (min_raw_len_q),
    .wr_o          (wr),
    .req_o         (req)
  );

  kfr_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  kfr_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[src/kfr_checker.sv]
// ----------------------------------------------------------------------------
// kfr_checker
// Port-level checks for the KISS frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kfr_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire kfr_pkg::in_word_t    in_word_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire kfr_pkg::out_word_t   out_word_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // a burst only starts after a frame end byte was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o &&
      in_word_i.op == kfr_pkg::OP_BYTE && in_word_i.rx_byte == kfr_pkg::FEND))
    else $error("burst started without a frame end");

  // a reset word never starts a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.op == kfr_pkg::OP_RESET |=> !in_stall_o)
    else $error("reset word started a burst");

  // new output words appear only during a burst
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word outside a burst");

endmodule

bind kiss_frame_receiver_unit kfr_checker u_kfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

[verif/kfr_frame_check.sv]
// ----------------------------------------------------------------------------
// kfr_frame_check
// Watches both channels of the KISS frame receiver, decodes every accepted
// input word into the expected frame bytes and compares each output word.
// ----------------------------------------------------------------------------

module kfr_frame_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  kfr_pkg::in_word_t           in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  kfr_pkg::out_word_t          out_word_i,
  input  logic                        cfg_we_i,
  input  logic [kfr_pkg::MinLenW-1:0] cfg_wdata_i,
  output int                          err_cnt_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          frames_o
);
  import kfr_pkg::*;

  // shadow receiver state
  rx_mode_e           mode_q;
  int                 raw_cnt;
  int                 kept_cnt;
  logic               esc_q;
  logic               ovf_q;
  logic [7:0]         frame_buf [MaxFrame];
  logic [MinLenW-1:0] min_len_q;

  // decoded bytes still owed by the block
  out_word_t frame_bytes_q [$];

  task automatic hold_byte(logic [7:0] b);
    if (kept_cnt < MaxFrame) begin
      frame_buf[kept_cnt] = b;
      kept_cnt++;
    end
  endtask

  // advance the shadow receiver by one input word
  task automatic decode_word(in_word_t w);
    out_word_t ow;
    if (w.op == OP_RESET) begin
      mode_q = MODE_HUNT;
      return;
    end
    case (mode_q)
      MODE_CMD: begin
        if (w.rx_byte == CMD_DATA) begin
          mode_q   = MODE_FRAME;
          raw_cnt  = 0;
          kept_cnt = 0;
          esc_q    = 1'b0;
          ovf_q    = 1'b0;
        end else if (w.rx_byte != FEND) begin
          mode_q = MODE_HUNT;
        end
      end
      MODE_FRAME: begin
        if (w.rx_byte == FEND) begin
          // closing delimiter releases the frame if long enough and intact
          if (!ovf_q && raw_cnt > min_len_q) begin
            for (int i = 0; i < kept_cnt; i++) begin
              ow.out_byte = frame_buf[i];
              ow.last     = (i == kept_cnt - 1);
              frame_bytes_q.push_back(ow);
            end
            if (kept_cnt > 0) frames_o++;
          end
          mode_q = MODE_CMD;
          esc_q  = 1'b0;
        end else if (!ovf_q) begin
          if (raw_cnt >= MaxFrame) begin
            ovf_q = 1'b1;
          end else begin
            raw_cnt++;
            if (esc_q) begin
              esc_q = 1'b0;
              if (w.rx_byte == TFESC) hold_byte(FESC);
              else if (w.rx_byte == TFEND) hold_byte(FEND);
            end else if (w.rx_byte == FESC) begin
              esc_q = 1'b1;
            end else begin
              hold_byte(w.rx_byte);
            end
          end
        end
      end
      default: begin
        mode_q = (w.rx_byte == FEND) ? MODE_CMD : MODE_HUNT;
      end
    endcase
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      mode_q    = MODE_HUNT;
      raw_cnt   = 0;
      kept_cnt  = 0;
      esc_q     = 1'b0;
      ovf_q     = 1'b0;
      min_len_q = MIN_RAW_RESET;
      frame_bytes_q.delete();
      err_cnt_o = 0;
      checked_o = 0;
      frames_o  = 0;
    end else begin
      if (cfg_we_i) min_len_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) decode_word(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        if (frame_bytes_q.size() == 0) begin
          $display("%0t: word expected none actual byte %h last %b", $time,
                   out_word_i.out_byte, out_word_i.last);
          err_cnt_o++;
        end else begin
          want = frame_bytes_q.pop_front();
          checked_o++;
          if (out_word_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     want.out_byte, out_word_i.out_byte);
            err_cnt_o++;
          end
          if (out_word_i.last !== want.last) begin
            $display("%0t: last expected %b actual %b (byte %h)", $time,
                     want.last, out_word_i.last, want.out_byte);
            err_cnt_o++;
          end
        end
      end
    end
    pending_o = frame_bytes_q.size();
  end

endmodule

[verif/kiss_frame_receiver_unit_tb.sv]
// ----------------------------------------------------------------------------
// kiss_frame_receiver_unit_tb
// Drives KISS link bytes into the frame receiver under random input gaps and
// output stalls, sweeping min_raw_len; the frame checker beside the block
// predicts and compares every released byte.
// ----------------------------------------------------------------------------

module kiss_frame_receiver_unit_tb;
  import kfr_pkg::*;

  localparam int RandWords    = 250;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 12;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  in_word_t           in_word   = '0;
  logic               out_stall = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [MinLenW-1:0] cfg_wdata = '0;
  logic               in_stall;
  logic               out_valid;
  out_word_t          out_word;

  int err_cnt;
  int pending;
  int checked;
  int frames;

  int                 cycles     = 0;
  int                 stall_left = 0;
  int                 words_sent = 0;
  int                 rand_words = 0;
  bit                 in_random  = 1'b0;
  bit                 calm       = 1'b0;
  logic [MinLenW-1:0] min_len    = MIN_RAW_RESET;

  always #1 clk = ~clk;

  kiss_frame_receiver_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  kfr_frame_check u_frame_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .frames_o    (frames)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles, pending);
      $display("[kiss_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none in calm phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // output back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // present one word and hold it until accepted
  task automatic send(logic op, logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_word  <= '{op: op, rx_byte: b};
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (in_random && op == OP_BYTE) rand_words++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every owed word come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_min_len(logic [MinLenW-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_len   = v;
  endtask

  // well-formed frame of raw_len raw bytes, optionally cut by a reset word
  task automatic send_frame(int raw_len, bit cut);
    int         left;
    int         pick;
    logic [7:0] b;
    send(OP_BYTE, FEND);
    send(OP_BYTE, CMD_DATA);
    left = raw_len;
    while (left > 0) begin
      pick = $urandom_range(0, 19);
      b    = 8'($urandom_range(0, 255));
      if (left >= 2 && pick < 2) begin
        send(OP_BYTE, FESC);
        send(OP_BYTE, TFEND);
        left -= 2;
      end else if (left >= 2 && pick < 4) begin
        send(OP_BYTE, FESC);
        send(OP_BYTE, TFESC);
        left -= 2;
      end else if (left >= 2 && pick == 4) begin
        // bad escape, a doubled escape byte among them
        send(OP_BYTE, FESC);
        send(OP_BYTE, (b == FEND) ? FESC : b);
        left -= 2;
      end else if (left == 1 && pick == 5) begin
        send(OP_BYTE, FESC);
        left--;
      end else begin
        if (b == FEND || b == FESC) b = b ^ 8'h01;
        send(OP_BYTE, b);
        left--;
      end
    end
    if (cut) send(OP_RESET, 8'($urandom_range(0, 255)));
    else send(OP_BYTE, FEND);
  endtask

  // raw length around the current threshold
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(min_len + 1, (min_len + 10 > MaxFrame) ?
                                     MaxFrame : min_len + 10);
    if (r < 9) return $urandom_range(0, min_len);
    return $urandom_range(MaxFrame + 1, MaxFrame + 4);
  endfunction

  // stray words, resets and wrong commands
  task automatic send_noise();
    int         r;
    logic [7:0] b;
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 9);
      b = 8'($urandom_range(0, 255));
      if (r == 0) send(OP_RESET, b);
      else if (r < 4) send(OP_BYTE, b);
      else if (r < 6) send(OP_BYTE, FEND);
      else if (r < 8) send(OP_BYTE, CMD_DATA);
      else send(OP_BYTE, FESC);
    end
  endtask

  initial begin
    logic [7:0] raw_seq [16];
    int         phase;
    int         phase_start;
    int         pick;
    int         plan [5];
    plan    = '{0, 63, 3, 14, 1};
    raw_seq = '{8'h00, 8'hFF, FESC, TFESC, FESC, TFEND, FESC, 8'h41,
                FESC, FESC, 8'h7E, 8'h80, 8'h01, TFEND, TFESC, FESC};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset threshold, command handling, all escape forms
    send(OP_RESET, 8'hFF);
    send(OP_BYTE, 8'h55);
    send(OP_BYTE, FEND);
    send(OP_BYTE, FEND);
    send(OP_BYTE, 8'h05);
    send(OP_BYTE, FEND);
    send(OP_BYTE, CMD_DATA);
    foreach (raw_seq[i]) send(OP_BYTE, raw_seq[i]);
    send(OP_BYTE, FEND);

    // directed: empty decode, reset inside a frame, one-byte frame
    set_min_len('0);
    send(OP_BYTE, CMD_DATA);
    send(OP_BYTE, FESC);
    send(OP_BYTE, FEND);
    send(OP_BYTE, CMD_DATA);
    send(OP_BYTE, 8'h11);
    send(OP_RESET, 8'h00);
    send(OP_BYTE, 8'h22);
    send(OP_BYTE, FEND);
    send(OP_BYTE, CMD_DATA);
    send(OP_BYTE, 8'hA5);
    send(OP_BYTE, FEND);

    // random phases, one threshold each
    in_random = 1'b1;
    phase     = 0;
    while (rand_words < RandWords) begin
      set_min_len(MinLenW'((phase < 5) ? plan[phase] : $urandom_range(0, 63)));
      calm        = (phase % 3 == 2);
      phase_start = rand_words;
      if (min_len == 63) begin
        send_frame(MaxFrame, 1'b0);
      end else begin
        if (phase == 2) send_frame(MaxFrame + 3, 1'b0);
        while (rand_words - phase_start < 45 && rand_words < RandWords) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) send_frame(pick_len(), 1'b0);
          else if (pick == 7) send_frame($urandom_range(1, min_len + 4), 1'b1);
          else send_noise();
        end
      end
      phase++;
    end
    calm = 1'b0;
    wait_drained();

    $display("sent %0d input words (%0d random) over %0d threshold phases",
             words_sent, rand_words, phase);
    $display("checked %0d output words in %0d released frames", checked, frames);
    if (err_cnt == 0 && pending == 0) begin
      $display("[kiss_frame_receiver_unit] OK");
    end else begin
      $display("[kiss_frame_receiver_unit] ERROR");
    end
    $finish;
  end

endmodule
